// File: rtl/sent_symbol_decoder_assert.svh
// Assertion macros shared by the symbol decoder RTL.
`ifndef SENT_SYMBOL_DECODER_ASSERT_SVH
`define SENT_SYMBOL_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Whenever cond holds on a clock edge, prop must hold on the same edge.
`define SENTD_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("sent_symbol_decoder: assertion failed");
// Whenever cond holds on a clock edge, prop must hold on the next edge.
`define SENTD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("sent_symbol_decoder: assertion failed");
`else
`define SENTD_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define SENTD_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// File: rtl/sentd_pkg.sv
// Types, register indexes and constants of the symbol decoder.
package sentd_pkg;

    localparam int PERIOD_WIDTH_DEFAULT = 24;

    // Configuration register widths and indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int TS_W       = 12;
    localparam int SYNC_W     = 8;
    localparam int PAUSE_W    = 10;
    localparam int MIN_W      = 8;
    localparam int NIB_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_SAMPLES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_NIBBLES = 3'd4;

    localparam logic [TS_W-1:0]    RST_TICK_SAMPLES = 12'd72;
    localparam logic [SYNC_W-1:0]  RST_SYNC_TICKS   = 8'd56;
    localparam logic [PAUSE_W-1:0] RST_PAUSE_TICKS  = 10'd77;
    localparam logic [MIN_W-1:0]   RST_MIN_TICKS    = 8'd12;
    localparam logic [NIB_W-1:0]   RST_DATA_NIBBLES = 4'd6;

    // Threshold widths: min*ts, nominal*ts, and the scaled window limits.
    localparam int MIN_THR_W = MIN_W + TS_W;
    localparam int NOM_W     = PAUSE_W + TS_W;
    localparam int THR_W     = NOM_W + 3;

    localparam int TICK_W = 8;
    localparam int KIND_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ERROR  = 3'd0,
        KIND_SYNC   = 3'd1,
        KIND_PAUSE  = 3'd2,
        KIND_STATUS = 3'd3,
        KIND_DATA   = 3'd4,
        KIND_CRC    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ARM_WAIT_HIGH = 2'd0,
        ARM_WAIT_FALL = 2'd1,
        ARM_MEASURE   = 2'd2
    } t_arm;

endpackage

// File: rtl/sent_symbol_decoder.sv
// SENT symbol decoder: turns a stream of line samples into sync, pause and nibble symbols.
// The block takes one sampled line level per transfer on the slave side and can take
// one in every clock cycle unless a symbol waits unaccepted in the output register.
// After reset it waits for the line to be high and then to fall; from then on it
// measures each pulse from one falling edge to the next and sends one symbol transfer
// on the master side for every falling edge except the first. A sample passes an
// input register and one stage of decode logic; the symbol for a falling edge is
// loaded into the output register as its sample leaves the input register, which
// no sample does while a symbol waits. The comparison thresholds (min_ticks, sync and
// pause windows, each multiplied by tick_samples) are held in registers that are
// recomputed every cycle from the configuration, so a register written in one cycle
// governs every sample taken from the next cycle on. The sample counter saturates at
// its full PERIOD_WIDTH range and the saturated value is both reported and used for
// classification. Nibble values are the rounded-up low plus high tick count minus
// min_ticks, modulo 256.
`include "sent_symbol_decoder_assert.svh"

module sent_symbol_decoder #(
    parameter int PERIOD_WIDTH = sentd_pkg::PERIOD_WIDTH_DEFAULT,
    parameter int OUT_W        = ((sentd_pkg::KIND_W + 8 + sentd_pkg::NIB_W
                                   + PERIOD_WIDTH + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [sentd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sentd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Sample stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [0] line_level
    // Symbol stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // From bit 0 up: symbol_kind (3), nibble_value (8), data_index (4),
    // period_samples (PERIOD_WIDTH), zero fill to whole bytes.
    output logic [OUT_W-1:0]                m_axis_tdata
);
    import sentd_pkg::*;

    localparam int CMP_W  = (PERIOD_WIDTH + 3 > THR_W) ? PERIOD_WIDTH + 3 : THR_W;
    localparam int MCMP_W = (PERIOD_WIDTH > MIN_THR_W) ? PERIOD_WIDTH : MIN_THR_W;

    // Configuration registers.
    logic [TS_W-1:0]    r_tick_samples;
    logic [SYNC_W-1:0]  r_sync_ticks;
    logic [PAUSE_W-1:0] r_pause_ticks;
    logic [MIN_W-1:0]   r_min_ticks;
    logic [NIB_W-1:0]   r_data_nibbles;

    // Derived thresholds.
    logic [MIN_THR_W-1:0] r_min_thr;
    logic [THR_W-1:0]     r_sync_lo, r_sync_hi, r_pause_lo, r_pause_hi;
    logic [NOM_W-1:0]     w_sync_nom, w_pause_nom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_samples <= RST_TICK_SAMPLES;
            r_sync_ticks   <= RST_SYNC_TICKS;
            r_pause_ticks  <= RST_PAUSE_TICKS;
            r_min_ticks    <= RST_MIN_TICKS;
            r_data_nibbles <= RST_DATA_NIBBLES;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TICK_SAMPLES: r_tick_samples <= i_cfg_data;
                CFG_SYNC_TICKS:   r_sync_ticks   <= i_cfg_data[SYNC_W-1:0];
                CFG_PAUSE_TICKS:  r_pause_ticks  <= i_cfg_data[PAUSE_W-1:0];
                CFG_MIN_TICKS:    r_min_ticks    <= i_cfg_data[MIN_W-1:0];
                CFG_DATA_NIBBLES: r_data_nibbles <= i_cfg_data[NIB_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_sync_nom  = NOM_W'(r_sync_ticks) * NOM_W'(r_tick_samples);
    assign w_pause_nom = NOM_W'(r_pause_ticks) * NOM_W'(r_tick_samples);

    // The windows are +-20%: 5p is compared against 4N and 6N.
    always_ff @(posedge i_clk) begin
        r_min_thr  <= MIN_THR_W'(r_min_ticks) * MIN_THR_W'(r_tick_samples);
        r_sync_lo  <= THR_W'({w_sync_nom, 2'b00});
        r_sync_hi  <= THR_W'({w_sync_nom, 2'b00}) + THR_W'({w_sync_nom, 1'b0});
        r_pause_lo <= THR_W'({w_pause_nom, 2'b00});
        r_pause_hi <= THR_W'({w_pause_nom, 2'b00}) + THR_W'({w_pause_nom, 1'b0});
    end

    // Input register.
    logic r_in_valid, r_in_level;
    logic w_advance;

    // Decoder state.
    t_arm                    r_arm, n_arm;
    logic                    r_prev, n_prev;
    logic                    r_high, n_high;
    logic [TS_W-1:0]         r_pre, n_pre;
    logic [TICK_W-1:0]       r_low_ticks, n_low_ticks;
    logic [TICK_W-1:0]       r_high_ticks, n_high_ticks;
    logic [PERIOD_WIDTH-1:0] r_count, n_count;
    logic                    r_status_seen, n_status_seen;
    logic [NIB_W-1:0]        r_data_pos, n_data_pos;

    // Output register.
    logic                    r_out_valid;
    t_kind                   r_out_kind, n_out_kind;
    logic [7:0]              r_out_value, n_out_value;
    logic [NIB_W-1:0]        r_out_index, n_out_index;
    logic [PERIOD_WIDTH-1:0] r_out_period;
    logic                    w_load;

    // A sample moves on whenever the output register is free or being emptied.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_level <= s_axis_tdata[0];
        end
    end

    // Period scaled by five for the window checks.
    logic [CMP_W-1:0] w_p5;
    logic             w_err, w_sync, w_pause;
    logic [TS_W:0]    w_tick_len;

    assign w_p5    = CMP_W'({r_count, 2'b00}) + CMP_W'(r_count);
    assign w_err   = MCMP_W'(r_count) < MCMP_W'(r_min_thr);
    assign w_sync  = (w_p5 > CMP_W'(r_sync_lo)) && (w_p5 < CMP_W'(r_sync_hi));
    assign w_pause = (w_p5 > CMP_W'(r_pause_lo)) && (w_p5 < CMP_W'(r_pause_hi));
    // A tick length of zero behaves as one sample.
    assign w_tick_len = (r_tick_samples == '0) ? (TS_W+1)'(1) : (TS_W+1)'(r_tick_samples);

    always_comb begin
        logic            v_start;
        logic            v_tick;
        logic            v_hp;
        logic [TS_W-1:0] v_pre;

        n_arm         = r_arm;
        n_prev        = r_prev;
        n_high        = r_high;
        n_pre         = r_pre;
        n_low_ticks   = r_low_ticks;
        n_high_ticks  = r_high_ticks;
        n_count       = r_count;
        n_status_seen = r_status_seen;
        n_data_pos    = r_data_pos;
        n_out_kind    = KIND_ERROR;
        n_out_value   = '0;
        n_out_index   = '0;
        w_load        = 1'b0;
        v_start       = 1'b0;
        v_tick        = 1'b0;
        v_hp          = r_high;
        v_pre         = r_pre;

        if (w_advance) begin
            n_prev = r_in_level;
            unique case (r_arm)
                ARM_WAIT_FALL: begin
                    if (!r_in_level) begin
                        v_start = 1'b1;
                    end
                end
                ARM_MEASURE: begin
                    if (!r_in_level && r_prev) begin
                        // Falling edge: classify the pulse that just ended.
                        w_load  = 1'b1;
                        v_start = 1'b1;
                        if (w_err) begin
                            n_out_kind = KIND_ERROR;
                        end else if (w_sync) begin
                            n_out_kind = KIND_SYNC;
                        end else if (w_pause) begin
                            n_out_kind = KIND_PAUSE;
                        end else begin
                            n_out_value = r_low_ticks + r_high_ticks - r_min_ticks;
                            if (!r_status_seen) begin
                                n_status_seen = 1'b1;
                                n_out_kind    = KIND_STATUS;
                            end else if (r_data_pos < r_data_nibbles) begin
                                n_out_kind  = KIND_DATA;
                                n_out_index = r_data_pos;
                                n_data_pos  = r_data_pos + 1'b1;
                            end else begin
                                n_out_kind    = KIND_CRC;
                                n_data_pos    = '0;
                                n_status_seen = 1'b0;
                            end
                        end
                    end else begin
                        if (r_count != '1) begin
                            n_count = r_count + 1'b1;
                        end
                        // Rising edge restarts the tick window for the high part.
                        if (r_in_level && !r_high) begin
                            v_hp  = 1'b1;
                            v_pre = '0;
                        end
                        v_tick = 1'b1;
                    end
                end
                default: begin
                    n_arm = r_in_level ? ARM_WAIT_FALL : ARM_WAIT_HIGH;
                end
            endcase

            if (v_start) begin
                n_arm        = ARM_MEASURE;
                v_hp         = 1'b0;
                v_pre        = '0;
                n_low_ticks  = '0;
                n_high_ticks = '0;
                n_count      = PERIOD_WIDTH'(1);
                v_tick       = 1'b1;
            end

            if (v_tick) begin
                // A tick counts on the first sample of its window.
                if (v_pre == '0) begin
                    if (v_hp) begin
                        n_high_ticks = n_high_ticks + 1'b1;
                    end else begin
                        n_low_ticks = n_low_ticks + 1'b1;
                    end
                end
                n_pre = ((TS_W+1)'(v_pre) + 1'b1 >= w_tick_len) ? '0 : v_pre + 1'b1;
            end
            n_high = v_hp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm         <= ARM_WAIT_HIGH;
            r_prev        <= 1'b0;
            r_high        <= 1'b0;
            r_pre         <= '0;
            r_low_ticks   <= '0;
            r_high_ticks  <= '0;
            r_count       <= '0;
            r_status_seen <= 1'b0;
            r_data_pos    <= '0;
        end else begin
            r_arm         <= n_arm;
            r_prev        <= n_prev;
            r_high        <= n_high;
            r_pre         <= n_pre;
            r_low_ticks   <= n_low_ticks;
            r_high_ticks  <= n_high_ticks;
            r_count       <= n_count;
            r_status_seen <= n_status_seen;
            r_data_pos    <= n_data_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_kind   <= n_out_kind;
            r_out_value  <= n_out_value;
            r_out_index  <= n_out_index;
            r_out_period <= r_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_period, r_out_index, r_out_value, r_out_kind});

    // Error, sync and pause symbols carry neither a nibble value nor an index.
    `SENTD_ASSERT_IMP(a_plain_kind_zero, i_clk, i_rst_n,
        r_out_valid && (r_out_kind == KIND_ERROR || r_out_kind == KIND_SYNC
                        || r_out_kind == KIND_PAUSE),
        r_out_value == '0 && r_out_index == '0)
    // Data positions only advance once the status nibble of the frame is seen.
    `SENTD_ASSERT_IMP(a_data_after_status, i_clk, i_rst_n,
        r_data_pos != '0, r_status_seen)
    // The sample side is held off only while both the input and the output register are full.
    `SENTD_ASSERT_IMP(a_stall_needs_sample, i_clk, i_rst_n,
        !s_axis_tready, r_in_valid && r_out_valid)
    // A new symbol is always measured from a counter that has been started.
    `SENTD_ASSERT_IMP(a_load_counted, i_clk, i_rst_n,
        w_load, r_arm == ARM_MEASURE && r_count != '0)

endmodule
